>>> hdl/bt2c_pkg.sv
package bt2c_pkg;

    localparam int CTX_W = 10;
    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd4096;

    localparam logic [CTX_W-1:0] CTX_KEEP = 10'h1bd;
    localparam logic [CTX_W-1:0] CTX_ABOVE_BIT = 10'h004;
    localparam logic [CTX_W-1:0] CTX_TWO_BIT = 10'h080;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic op;
        logic pixel_bit;
    } t_in;

    typedef struct packed {
        logic [CTX_W-1:0] next_context;
        logic [7:0]       packed_byte;
        logic             byte_ready;
        logic             row_done;
    } t_out;

    // one column of history: pixel two rows up and pixel one row up
    typedef struct packed {
        logic two;
        logic above;
    } t_hist;

endpackage

>>> hdl/bt2c_line_mem.sv
module bt2c_line_mem #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_waddr,
    input  bt2c_pkg::t_hist               i_wdata,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_raddr,
    output bt2c_pkg::t_hist               o_rdata
);
    import bt2c_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_hist r_mem [MAX_WIDTH];
    t_hist r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else if ((AW + 1)'(i_raddr) < (AW + 1)'(MAX_WIDTH)) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bt2c_step.sv
module bt2c_step #(
    parameter int MAX_WIDTH = 4096
) (
    input  bt2c_pkg::t_in                          i_item,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_col,
    input  logic [1:0]                             i_rows,
    input  logic [bt2c_pkg::CTX_W-1:0]             i_ctx,
    input  logic [7:0]                             i_shift,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_width,
    input  bt2c_pkg::t_hist [3:0]                  i_win,
    input  bt2c_pkg::t_hist [3:0]                  i_head,
    input  bt2c_pkg::t_hist                        i_rdata,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_col,
    output logic [1:0]                             o_rows,
    output logic [bt2c_pkg::CTX_W-1:0]             o_ctx,
    output logic [7:0]                             o_shift,
    output bt2c_pkg::t_hist [3:0]                  o_win,
    output bt2c_pkg::t_hist [3:0]                  o_head,
    output bt2c_pkg::t_hist                        o_wdata,
    output bt2c_pkg::t_out                         o_res
);
    import bt2c_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = WW + 2;

    logic [CW-1:0]    c_ext;
    logic [CW-1:0]    w_ext;
    logic             last;
    logic [7:0]       shift_or;
    logic [1:0]       rows_inc;
    t_hist            wr;
    t_hist [3:0]      head_new;
    logic             a3;
    logic             t2;
    logic [2:0]       in_w;
    logic [CTX_W-1:0] ctx_run;
    logic [CTX_W-1:0] ctx_row;

    always_comb begin
        c_ext    = CW'(i_col);
        w_ext    = CW'(i_width);
        last     = (c_ext + CW'(1)) >= w_ext;
        shift_or = i_shift | (8'(i_item.pixel_bit) << (3'd7 - i_col[2:0]));
        rows_inc = (i_rows == 2'd2) ? 2'd2 : i_rows + 2'd1;
        wr.two   = i_win[0].above;
        wr.above = i_item.pixel_bit;

        head_new = i_head;
        if ((i_col >> 2) == '0) begin
            head_new[i_col[1:0]] = wr;
        end

        a3 = (i_rows != 2'd0) && ((c_ext + CW'(3)) < w_ext) && i_win[3].above;
        t2 = (i_rows == 2'd2) && ((c_ext + CW'(2)) < w_ext) && i_win[2].two;
        ctx_run = ((i_ctx & CTX_KEEP) << 1) | CTX_W'(i_item.pixel_bit)
                | (a3 ? CTX_ABOVE_BIT : '0) | (t2 ? CTX_TWO_BIT : '0);

        for (int i = 0; i < 3; i++) begin
            in_w[i] = CW'(i) < w_ext;
        end
        ctx_row = '0;
        ctx_row[4] = in_w[0] && head_new[0].above;
        ctx_row[3] = in_w[1] && head_new[1].above;
        ctx_row[2] = in_w[2] && head_new[2].above;
        ctx_row[8] = (rows_inc == 2'd2) && in_w[0] && head_new[0].two;
        ctx_row[7] = (rows_inc == 2'd2) && in_w[1] && head_new[1].two;

        o_wdata = wr;
        o_head  = head_new;
        o_res   = '0;

        unique case (i_item.op)
            OP_START: begin
                o_col   = '0;
                o_rows  = 2'd0;
                o_ctx   = '0;
                o_shift = '0;
                o_win   = i_head;
                o_head  = i_head;
            end
            default: begin
                if (last) begin
                    o_col   = '0;
                    o_rows  = rows_inc;
                    o_ctx   = ctx_row;
                    o_shift = '0;
                    o_win   = head_new;
                    o_res.packed_byte = shift_or;
                    o_res.byte_ready  = 1'b1;
                    o_res.row_done    = 1'b1;
                end else begin
                    o_col  = i_col + AW'(1);
                    o_rows = i_rows;
                    o_ctx  = ctx_run;
                    o_win  = {i_rdata, i_win[3], i_win[2], i_win[1]};
                    if (i_col[2:0] == 3'd7) begin
                        o_shift = '0;
                        o_res.packed_byte = shift_or;
                        o_res.byte_ready  = 1'b1;
                    end else begin
                        o_shift = shift_or;
                    end
                end
                o_res.next_context = o_ctx;
            end
        endcase
    end

endmodule

>>> hdl/bilevel_template2_context_model.sv
// template 2 context model for a bilevel generic-region decoder
// input channel (i_in_valid / o_in_ready / i_in_data): one command per transfer,
//   either start of image (clears row history use, column and context) or one
//   decoded pixel bit, decoded under the last next_context handed out
// output channel (o_out_valid / i_out_ready / o_out_data): exactly one result per
//   input transfer: context for the next pixel, plus a packed byte at every
//   eighth pixel and at row end, and a row-done flag
// latency: the result is visible the cycle after the input transfer
// throughput: one item per cycle while o_in_ready is high; the line history is one
//   2-bit-wide memory, one write and one registered read per cycle, read four columns
//   ahead while the first four columns of the row also sit in flops
// the row width register (i_cfg_we / i_cfg_wdata) is written at any edge with
//   i_cfg_we high; 0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH
// reset: synchronous, active low; column, context and row count clear, the
//   width returns to 4096, the history memory is left as is
// stall: a held result blocks a new transfer only if i_out_ready stays low;
//   the output register is freed and refilled in the same cycle
module bilevel_template2_context_model #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  bt2c_pkg::t_in           i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output bt2c_pkg::t_out          o_out_data,
    input  logic                    i_cfg_we,
    input  logic [bt2c_pkg::CFG_W-1:0] i_cfg_wdata
);
    import bt2c_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;

    logic [AW-1:0]    r_col,   n_col;
    logic [1:0]       r_rows,  n_rows;
    logic [CTX_W-1:0] r_ctx,   n_ctx;
    logic [7:0]       r_shift, n_shift;
    t_hist [3:0]      r_win,   n_win;
    t_hist [3:0]      r_head,  n_head;
    logic [CFG_W-1:0] r_width;
    logic             r_out_valid;
    t_out             r_out_data;

    logic [AW-1:0]    s_col;
    logic [1:0]       s_rows;
    logic [CTX_W-1:0] s_ctx;
    logic [7:0]       s_shift;
    t_hist [3:0]      s_win;
    t_hist [3:0]      s_head;
    t_hist            s_wdata;
    t_out             s_res;
    t_hist            rdata;
    logic [WW-1:0]    width_eff;
    logic             in_xfer;
    logic             mem_we;

    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign mem_we     = in_xfer && (i_in_data.op == OP_PIXEL);

    bt2c_step #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_step (
        .i_item  (i_in_data),
        .i_col   (r_col),
        .i_rows  (r_rows),
        .i_ctx   (r_ctx),
        .i_shift (r_shift),
        .i_width (width_eff),
        .i_win   (r_win),
        .i_head  (r_head),
        .i_rdata (rdata),
        .o_col   (s_col),
        .o_rows  (s_rows),
        .o_ctx   (s_ctx),
        .o_shift (s_shift),
        .o_win   (s_win),
        .o_head  (s_head),
        .o_wdata (s_wdata),
        .o_res   (s_res)
    );

    always_comb begin
        n_col   = r_col;
        n_rows  = r_rows;
        n_ctx   = r_ctx;
        n_shift = r_shift;
        n_win   = r_win;
        n_head  = r_head;
        if (in_xfer) begin
            n_col   = s_col;
            n_rows  = s_rows;
            n_ctx   = s_ctx;
            n_shift = s_shift;
            n_win   = s_win;
            n_head  = s_head;
        end
    end

    bt2c_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_col),
        .i_wdata (s_wdata),
        .i_raddr (n_col + AW'(4)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_rows      <= 2'd0;
            r_ctx       <= '0;
            r_shift     <= '0;
            r_width     <= WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_ctx   <= n_ctx;
            r_shift <= n_shift;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_head <= n_head;
        if (in_xfer) begin
            r_out_data <= s_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sim/bilevel_template2_context_model_test.sv
`timescale 1ns / 1ps

module bilevel_template2_context_model_test;
    import bt2c_pkg::*;

    class context_scoreboard;
        localparam int HIST_DEPTH = 4096;

        bit               hist_above [HIST_DEPTH];
        bit               hist_two [HIST_DEPTH];
        logic [CTX_W-1:0] ctx;
        int unsigned      col;
        int unsigned      rows_done;
        logic [7:0]       byte_acc;
        logic [CFG_W-1:0] width_reg;
        t_out             expected_results [$];
        int               fail_count;

        function new();
            ctx = '0;
            col = 0;
            rows_done = 0;
            byte_acc = '0;
            width_reg = WIDTH_RESET;
            fail_count = 0;
        endfunction

        function int unsigned row_span();
            if (width_reg == 0) return 1;
            if (width_reg > HIST_DEPTH) return HIST_DEPTH;
            return width_reg;
        endfunction

        function bit above(int unsigned i, int unsigned w);
            if (rows_done < 1 || i >= w || i >= HIST_DEPTH) return 1'b0;
            return hist_above[i];
        endfunction

        function bit two_above(int unsigned i, int unsigned w);
            if (rows_done < 2 || i >= w || i >= HIST_DEPTH) return 1'b0;
            return hist_two[i];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // predict the result of one accepted input transfer
        function void note_input(t_in item);
            t_out        r;
            int unsigned w;
            int unsigned c;
            w = row_span();
            r = '0;
            if (item.op == OP_START) begin
                col = 0;
                rows_done = 0;
                ctx = '0;
                byte_acc = '0;
                expected_results.push_back(r);
                return;
            end
            c = col;
            if (c >= HIST_DEPTH) c = HIST_DEPTH - 1;
            byte_acc[7 - (c % 8)] = byte_acc[7 - (c % 8)] | item.pixel_bit;
            hist_two[c] = hist_above[c];
            hist_above[c] = item.pixel_bit;
            if (c + 1 >= w) begin
                r.row_done = 1'b1;
                r.byte_ready = 1'b1;
                r.packed_byte = byte_acc;
                byte_acc = '0;
                col = 0;
                if (rows_done < 2) rows_done++;
                ctx = '0;
                ctx[4] = above(0, w);
                ctx[3] = above(1, w);
                ctx[2] = above(2, w);
                ctx[8] = two_above(0, w);
                ctx[7] = two_above(1, w);
            end else begin
                if (c % 8 == 7) begin
                    r.byte_ready = 1'b1;
                    r.packed_byte = byte_acc;
                    byte_acc = '0;
                end
                col = c + 1;
                ctx = ((ctx & CTX_KEEP) << 1) | {{(CTX_W-1){1'b0}}, item.pixel_bit}
                    | (above(c + 3, w) ? CTX_ABOVE_BIT : '0)
                    | (two_above(c + 2, w) ? CTX_TWO_BIT : '0);
            end
            r.next_context = ctx;
            expected_results.push_back(r);
        endfunction

        task report(string field, int got, int want);
            $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
            fail_count++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                report("unexpected transfer", got, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.next_context !== want.next_context)
                report("next_context", got.next_context, want.next_context);
            if (got.packed_byte !== want.packed_byte)
                report("packed_byte", got.packed_byte, want.packed_byte);
            if (got.byte_ready !== want.byte_ready)
                report("byte_ready", got.byte_ready, want.byte_ready);
            if (got.row_done !== want.row_done)
                report("row_done", got.row_done, want.row_done);
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in              in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_data;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    bit                 calm;
    int                 random_items;
    context_scoreboard  sb;

    bilevel_template2_context_model u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    task send_item(input logic op, input logic pix);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data.op = op;
        in_data.pixel_bit = pix;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_input(in_data);
        @(negedge i_clk);
    endtask

    task drain();
        in_valid = 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    task write_width(input logic [CFG_W-1:0] v);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.width_reg = v;
    endtask

    task run_image(input logic [CFG_W-1:0] wval, input bit big);
        int unsigned w;
        int          npix;
        int          shrink_at;
        int          bias;
        int          k;
        logic        pix;
        logic [CFG_W-1:0] nv;
        calm = ($urandom_range(0, 3) == 0);
        write_width(wval);
        w = sb.row_span();
        if (big) npix = 40;
        else if (w > 40) npix = w * $urandom_range(1, 2);
        else npix = w * $urandom_range(1, 6);
        shrink_at = (!big && npix > 2 && $urandom_range(0, 5) == 0) ?
            $urandom_range(1, npix - 1) : -1;
        bias = $urandom_range(0, 3);
        send_item(OP_START, 1'($urandom_range(0, 1)));
        if (!big) random_items++;
        for (k = 0; k < npix; k++) begin
            if (k == shrink_at) begin
                // a row no wider than the current one inside the image, history stays valid
                drain();
                nv = CFG_W'($urandom_range(0, w));
                write_width(nv);
                w = sb.row_span();
            end
            if (!big && $urandom_range(0, 99) < 2) begin
                send_item(OP_START, 1'($urandom_range(0, 1)));
                random_items++;
            end
            case (bias)
                0: pix = 1'b0;
                1: pix = 1'b1;
                default: pix = 1'($urandom_range(0, 1));
            endcase
            send_item(OP_PIXEL, pix);
            if (!big) random_items++;
        end
        drain();
    endtask

    initial begin
        int               stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            sb.check_result(out_data);
            @(negedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [17:0]      pat;
        logic [CFG_W-1:0] fixed_widths [8];
        int               p;
        int               k;
        sb = new();
        calm = 1'b0;
        random_items = 0;
        pat = 18'b10110011_11111111_01;
        fixed_widths = '{13'd0, 13'd1, 13'd8, 13'd8191, 13'd9, 13'd7, 13'd16, 13'd2};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset width, then a narrower width inside a row, then a full row
        send_item(OP_START, 1'b1);
        for (k = 0; k < 18; k++) send_item(OP_PIXEL, pat[17 - k]);
        drain();
        write_width(13'd5);
        send_item(OP_PIXEL, 1'b1);
        for (k = 0; k < 5; k++) send_item(OP_PIXEL, k[0]);
        drain();

        p = 0;
        while (p < 8 || random_items < 650) begin
            if (p < 8)
                run_image(fixed_widths[p], fixed_widths[p] == 13'd8191);
            else if ($urandom_range(0, 9) == 0)
                run_image(CFG_W'($urandom_range(41, 200)), 1'b0);
            else
                run_image(CFG_W'($urandom_range(1, 40)), 1'b0);
            p++;
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
